@@ src/bia_pkg.sv @@
// ----------------------------------------------------------------------------
// bia_pkg: shared types and constants for the bounded insertable array
// Field widths, operation and status codes, and the beat payload structs.
// ----------------------------------------------------------------------------
package bia_pkg;

    // Array geometry
    localparam int MAX_ENTRIES    = 1024;
    localparam int START_CAPACITY = 16;
    localparam int DATA_W         = 32;
    localparam int POS_W          = 10;
    localparam int CNT_W          = 10;
    localparam int CAP_W          = 11;
    localparam int FUNC_W         = 3;
    localparam int STAT_W         = 2;

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_ENTRIES);
    localparam logic [CAP_W-1:0] CAP_START = CAP_W'(START_CAPACITY);

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_IOB  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
        logic [CAP_W-1:0]         cur_capacity;
        logic                     is_empty;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the input beat
        logic rd_pos;    // read entry at position
        logic sh_first;  // read the last entry to start a shift
        logic sh_step;   // move one entry up, read the next one down
        logic wr_pos;    // write the new value
        logic finish;    // commit state, load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              idx_bad;
        logic              full;
        logic              shift_need;
        logic              shift_last;
        logic              out_free;
    } t_dp_stat;

endpackage

@@ src/bia_ram.sv @@
// ----------------------------------------------------------------------------
// bia_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bia_dp.sv @@
// ----------------------------------------------------------------------------
// bia_dp: datapath of the bounded insertable array
// Entry memory, count and capacity registers, shift pointer and result register.
// ----------------------------------------------------------------------------
module bia_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bia_pkg::t_dp_cmd   i_cmd,
    output bia_pkg::t_dp_stat  o_stat,
    input  bia_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_data,
    output logic               o_out_valid,
    output bia_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import bia_pkg::*;

    // Latched operation
    logic [FUNC_W-1:0]        r_func;
    logic [POS_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] r_val;

    // Array state
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic [POS_W-1:0] r_rd, n_rd;

    // Result register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    // RAM ports
    logic              ram_we, ram_re;
    logic [POS_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic             need_grow, at_max, full, idx_bad;
    logic [CAP_W:0]   cap_dbl;
    logic [CAP_W-1:0] cap_grown, cfg_cap;
    logic [STAT_W-1:0] res_status;
    logic [DATA_W-1:0] res_rd;

    bia_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Room check and growth
    always_comb begin
        need_grow = ({1'b0, r_fill} + CAP_W'(1)) >= r_cap;
        at_max    = r_cap >= CAP_MAX;
        full      = need_grow && at_max;
        cap_dbl   = {r_cap, 1'b0};
        cap_grown = (cap_dbl > {1'b0, CAP_MAX}) ? CAP_MAX : cap_dbl[CAP_W-1:0];
    end

    // Index check per operation
    always_comb begin
        case (r_func)
            FN_READ:   idx_bad = r_pos >= r_fill;
            FN_INSERT: idx_bad = r_pos > r_fill;
            default:   idx_bad = 1'b0;
        endcase
    end

    assign o_stat.func       = r_func;
    assign o_stat.idx_bad    = idx_bad;
    assign o_stat.full       = full;
    assign o_stat.shift_need = r_pos != r_fill;
    assign o_stat.shift_last = r_rd == r_pos;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    // Capacity register write, clamped to the legal range
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = CAP_W'(1);
        end else if (i_cfg_data > CAP_MAX) begin
            cfg_cap = CAP_MAX;
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    // Memory access steering
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_pos;
        ram_raddr = r_pos;
        ram_wdata = r_val;
        n_rd      = r_rd;
        if (i_cmd.rd_pos) begin
            ram_re = 1'b1;
        end
        if (i_cmd.sh_first) begin
            ram_re    = 1'b1;
            ram_raddr = r_fill - POS_W'(1);
            n_rd      = r_fill - POS_W'(1);
        end
        if (i_cmd.sh_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd + POS_W'(1);
            ram_wdata = ram_rdata;
            if (r_rd != r_pos) begin
                ram_re    = 1'b1;
                ram_raddr = r_rd - POS_W'(1);
                n_rd      = r_rd - POS_W'(1);
            end
        end
        if (i_cmd.wr_pos) begin
            ram_we    = 1'b1;
            ram_waddr = (r_func == FN_PUSH) ? r_fill : r_pos;
        end
    end

    // Commit values for the finished operation
    always_comb begin
        n_fill     = r_fill;
        n_cap      = r_cap;
        res_status = ST_OK;
        res_rd     = '0;
        case (r_func)
            FN_READ: begin
                if (idx_bad) begin
                    res_status = ST_IOB;
                end else begin
                    res_rd = ram_rdata;
                end
            end
            FN_INSERT, FN_PUSH: begin
                if (idx_bad) begin
                    res_status = ST_IOB;
                end else if (full) begin
                    res_status = ST_FULL;
                end else begin
                    n_fill = r_fill + CNT_W'(1);
                    if (need_grow) begin
                        n_cap = cap_grown;
                    end
                end
            end
            FN_POP: begin
                if (r_fill != '0) begin
                    n_fill = r_fill - CNT_W'(1);
                end
            end
            FN_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
        n_out.status       = res_status;
        n_out.read_value   = res_rd;
        n_out.count        = n_fill;
        n_out.cur_capacity = n_cap;
        n_out.is_empty     = n_fill == '0;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cap       <= CAP_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fill <= '0;
                r_cap  <= cfg_cap;
            end else if (i_cmd.finish) begin
                r_fill <= n_fill;
                r_cap  <= n_cap;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        if (i_cmd.latch) begin
            r_func <= i_in_data.func;
            r_pos  <= i_in_data.position;
            r_val  <= i_in_data.value;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/bia_ctrl.sv @@
// ----------------------------------------------------------------------------
// bia_ctrl: operation sequencer of the bounded insertable array
// Steps each operation through decode, entry shift, write and result load.
// ----------------------------------------------------------------------------
module bia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_cfg_ready,
    output bia_pkg::t_dp_cmd  o_cmd,
    input  bia_pkg::t_dp_stat i_stat
);
    import bia_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (i_stat.func)
                    FN_READ: begin
                        o_cmd.rd_pos = !i_stat.idx_bad;
                    end
                    FN_INSERT: begin
                        if (!i_stat.idx_bad && !i_stat.full) begin
                            if (i_stat.shift_need) begin
                                o_cmd.sh_first = 1'b1;
                                n_state        = S_SHIFT;
                            end else begin
                                n_state = S_WRITE;
                            end
                        end
                    end
                    FN_PUSH: begin
                        if (!i_stat.full) begin
                            n_state = S_WRITE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                o_cmd.sh_step = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_pos = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = r_state == S_IDLE;

endmodule

@@ src/bounded_insertable_array_top.sv @@
// ----------------------------------------------------------------------------
// bounded_insertable_array_top: bounded array with insert-and-shift
// Read, insert, push, pop and clear on up to 1023 signed 32-bit entries.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Beat
// in       input      i_in_valid/o_in_stall   t_in_item (func, position, value)
// out      output     o_out_valid/i_out_stall t_out_item (status .. is_empty)
// cfg      input      i_cfg_valid/o_cfg_ready initial capacity, 11 bits
//
// Read, pop, clear, no-op and rejected beats pass through decode and result
// load; push adds a write step before the result load.
// Insert at position p with n entries stored moves n - p entries up, each
// through the entry RAM's write port, before the new value is written.
// A new beat is taken only once the previous operation has loaded its result.
// The result register holds a stalled result while the next beat is taken;
// a finished operation waits in place until that register is free.
// Synchronous reset: count 0, capacity 16, no result pending, memory untouched.
// ----------------------------------------------------------------------------
module bounded_insertable_array_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bia_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output bia_pkg::t_out_item o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    input  logic [10:0]        i_cfg_data,
    output logic               o_cfg_ready
);
    import bia_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_ready;

    bia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (cfg_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bia_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    assign o_cfg_ready = cfg_ready;

endmodule

@@ tb/tb_bounded_insertable_array_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_insertable_array_top: self-checking bench for the insertable array
// Drives read/insert/push/pop/clear beats with random idle and stall bursts.
// A scoreboard keeps its own copy of the array, count and capacity. It checks
// every result beat field by field against the expected one, in order.
// ----------------------------------------------------------------------------
module tb_bounded_insertable_array_top;
    import bia_pkg::*;

    // Function codes the block treats as no-ops
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

    localparam int          GROWTH      = 2;
    localparam int          RANDOM_OPS  = 380;
    localparam int          FILL_BOUND  = 48;    // keeps random inserts short
    localparam int          DEEP_FILL   = 120;   // several doublings from 3
    localparam int          SETTLE      = 12;    // quiet cycles after draining, before cfg writes
    localparam int          ERR_REPORTS = 100;
    localparam int unsigned LIMIT       = 6_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow array, expected result queue, field compare
    // ------------------------------------------------------------------------
    class array_scoreboard;
        logic signed [DATA_W-1:0] shadow [0:MAX_ENTRIES-1];
        int unsigned              fill;
        int unsigned              cap;
        t_out_item                awaited [$];
        int                       errors;
        int                       n_beats;
        int                       n_checked;
        int                       n_iob;
        int                       n_full;
        int unsigned              peak_fill;

        function new();
            fill = 0;
            cap  = START_CAPACITY;
        endfunction

        // Capacity register write: clamp to 1..MAX, array starts empty
        function void load_capacity(logic [CAP_W-1:0] v);
            if (v == 0) cap = 1;
            else if (v > MAX_ENTRIES) cap = MAX_ENTRIES;
            else cap = v;
            fill = 0;
        endfunction

        // Room for one more entry, doubling capacity when needed
        function bit make_space();
            if (fill + 1 < cap) return 1'b1;
            if (cap >= MAX_ENTRIES) return 1'b0;
            cap = (cap * GROWTH > MAX_ENTRIES) ? MAX_ENTRIES : cap * GROWTH;
            return 1'b1;
        endfunction

        // Accepted input beat: update shadow state, queue the expected result
        function void note_item(t_in_item it);
            t_out_item   exp;
            int unsigned p;
            int unsigned k;
            exp = '0;
            p   = it.position;
            case (it.func)
                FN_READ: begin
                    if (p >= fill) exp.status = ST_IOB;
                    else exp.read_value = shadow[p];
                end
                FN_INSERT: begin
                    if (p > fill) begin
                        exp.status = ST_IOB;
                    end else if (!make_space() || fill >= MAX_ENTRIES) begin
                        exp.status = ST_FULL;
                    end else begin
                        for (k = fill; k > p; k--) shadow[k] = shadow[k-1];
                        shadow[p] = it.value;
                        fill++;
                    end
                end
                FN_PUSH: begin
                    if (!make_space() || fill >= MAX_ENTRIES) begin
                        exp.status = ST_FULL;
                    end else begin
                        shadow[fill] = it.value;
                        fill++;
                    end
                end
                FN_POP: begin
                    if (fill > 0) fill--;
                end
                FN_CLEAR: begin
                    fill = 0;
                end
                default: ;
            endcase
            exp.count        = CNT_W'(fill);
            exp.cur_capacity = CAP_W'(cap);
            exp.is_empty     = (fill == 0);
            if (exp.status == ST_IOB) n_iob++;
            if (exp.status == ST_FULL) n_full++;
            if (fill > peak_fill) peak_fill = fill;
            n_beats++;
            awaited = {awaited, exp};
        endfunction

        function void report(string field, longint e, longint a);
            errors++;
            if (errors <= ERR_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", field, e, a);
        endfunction

        // Result beat: compare with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item exp;
            if (awaited.size() == 0) begin
                errors++;
                $error("result beat with no expectation pending");
                return;
            end
            exp = awaited.pop_front();
            n_checked++;
            if (got.status !== exp.status) report("status", exp.status, got.status);
            if (got.read_value !== exp.read_value)
                report("read_value", exp.read_value, got.read_value);
            if (got.count !== exp.count) report("count", exp.count, got.count);
            if (got.cur_capacity !== exp.cur_capacity)
                report("cur_capacity", exp.cur_capacity, got.cur_capacity);
            if (got.is_empty !== exp.is_empty)
                report("is_empty", exp.is_empty, got.is_empty);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    t_in_item         in_data = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_data;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CAP_W-1:0] cfg_data = '0;
    logic             cfg_ready;
    bit               idle_on = 1'b0;
    int unsigned      cycles = 0;

    array_scoreboard sb = new();

    initial begin
        forever #5 clk = ~clk;
    end

    bounded_insertable_array_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor: a beat moves when valid is high and stall is low
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(out_data);
    end

    // Receiver back-pressure in random bursts
    initial begin
        int hold;
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item mk(logic [FUNC_W-1:0] f, int unsigned p,
                                    logic [DATA_W-1:0] v);
        t_in_item it;
        it.func     = f;
        it.position = POS_W'(p);
        it.value    = v;
        return it;
    endfunction

    // Send one beat, with an optional idle burst ahead of it
    task automatic drive_item(input t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_item(it);
    endtask

    // Stop sending and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.load_capacity(v);
    endtask

    // Random beat, mostly well-formed against the current fill
    function automatic t_in_item pick_random_item();
        t_in_item    it;
        int unsigned n;
        int unsigned roll;
        n           = sb.fill;
        roll        = $urandom_range(0, 99);
        it.func     = FN_READ;
        it.position = POS_W'($urandom);
        it.value    = $urandom;
        if ($urandom_range(0, 15) == 0)
            it.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (n >= FILL_BOUND && $urandom_range(0, 1) == 0) begin
            it.func = FN_POP;
        end else if (roll < 30) begin
            it.func = FN_PUSH;
        end else if (roll < 55) begin
            it.func = FN_INSERT;
            if ($urandom_range(0, 9) != 0) it.position = POS_W'($urandom_range(0, n));
        end else if (roll < 82) begin
            it.func = FN_READ;
            if (n > 0 && $urandom_range(0, 4) != 0)
                it.position = POS_W'($urandom_range(0, n - 1));
        end else if (roll < 94) begin
            it.func = FN_POP;
        end else if (roll < 97) begin
            it.func = FN_CLEAR;
        end else begin
            case ($urandom_range(0, 2))
                0:       it.func = FN_SPARE_A;
                1:       it.func = FN_SPARE_B;
                default: it.func = FN_SPARE_C;
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int               sent;
        int               chunk;
        int               c;
        int               i;
        logic [CAP_W-1:0] cap_pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty-array corners, value extremes, no-op codes
        drive_item(mk(FN_READ, 0, $urandom));
        drive_item(mk(FN_POP, 0, 0));
        drive_item(mk(FN_INSERT, 1, $urandom));
        drive_item(mk(FN_INSERT, 0, 32'h8000_0000));
        drive_item(mk(FN_PUSH, 1023, 32'h7FFF_FFFF));
        drive_item(mk(FN_INSERT, 1, 32'hFFFF_FFFF));
        drive_item(mk(FN_READ, 0, 0));
        drive_item(mk(FN_READ, 1, 0));
        drive_item(mk(FN_READ, 2, 0));
        drive_item(mk(FN_READ, 3, 0));
        drive_item(mk(FN_READ, 1023, 32'hFFFF_FFFF));
        drive_item(mk(FN_INSERT, 3, 32'h0000_0000));
        drive_item(mk(FN_INSERT, 1023, $urandom));
        drive_item(mk(FN_READ, 3, 0));
        drive_item(mk(FN_SPARE_A, $urandom_range(0, 1023), $urandom));
        drive_item(mk(FN_SPARE_B, $urandom_range(0, 1023), $urandom));
        drive_item(mk(FN_SPARE_C, 1023, 32'hFFFF_FFFF));
        drive_item(mk(FN_POP, 0, 0));
        drive_item(mk(FN_CLEAR, 0, 0));
        drive_item(mk(FN_READ, 0, 0));

        // Capacity 0 loads as 1, then doubles as the pushes fill it
        write_capacity(11'd0);
        for (i = 0; i < 4; i++) drive_item(mk(FN_PUSH, 0, $urandom));
        write_capacity(11'h7FF);
        drive_item(mk(FN_PUSH, 0, $urandom));

        // Random phase: chunks with varying capacity and idling
        sent  = 0;
        c     = 0;
        while (sent < RANDOM_OPS) begin
            case (c % 6)
                0:       cap_pick = 11'd1;
                1:       cap_pick = 11'd1024;
                2:       cap_pick = CAP_W'($urandom_range(1, 2047));
                default: cap_pick = CAP_W'($urandom_range(1, 40));
            endcase
            write_capacity(cap_pick);
            idle_on = ($urandom_range(0, 3) != 0);
            chunk   = $urandom_range(30, 52);
            for (i = 0; i < chunk; i++) drive_item(pick_random_item());
            sent += chunk;
            c++;
        end

        // Deep fill: grow from 3 through several doublings
        write_capacity(11'd3);
        idle_on = 1'b1;
        while (sb.fill < DEEP_FILL) begin
            if ($urandom_range(0, 49) == 0)
                drive_item(mk(FN_READ, $urandom_range(0, sb.fill), 0));
            else
                drive_item(mk(FN_PUSH, $urandom, $urandom));
        end
        drive_item(mk(FN_INSERT, sb.fill + 1, $urandom));
        drive_item(mk(FN_READ, sb.fill, 0));
        drive_item(mk(FN_READ, sb.fill - 1, 0));
        // Long shifts across the whole stored range
        drive_item(mk(FN_INSERT, 0, $urandom));
        drive_item(mk(FN_POP, 0, 0));
        drive_item(mk(FN_INSERT, 1, $urandom));
        drive_item(mk(FN_INSERT, sb.fill / 2, $urandom));
        for (i = 0; i < 20; i++) drive_item(mk(FN_READ, $urandom_range(0, sb.fill - 1), 0));
        drive_item(mk(FN_PUSH, 0, $urandom));
        drive_item(mk(FN_READ, 0, 0));
        drive_item(mk(FN_CLEAR, 0, 0));

        // Last part: back-to-back beats, no idling on either side
        write_capacity(CAP_W'($urandom_range(2, 8)));
        idle_on = 1'b0;
        for (i = 0; i < 30; i++) drive_item(pick_random_item());

        drain();
        sb.errors += sb.awaited.size();

        $display("Ran %0d beats, checked %0d results: %0d out of range, %0d full.",
                 sb.n_beats, sb.n_checked, sb.n_iob, sb.n_full);
        $display("Peak array count %0d across %0d capacity settings.",
                 sb.peak_fill, c + 4);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/bia_pkg.sv
src/bia_ram.sv
src/bia_dp.sv
src/bia_ctrl.sv
src/bounded_insertable_array_top.sv
tb/tb_bounded_insertable_array_top.sv
